// ===== rtl/mbps_pkg.sv =====
// Shared types, register codes and the masked byte compare of the pattern scanner.
package mbps_pkg;

	// Default values of the top level parameters.
	localparam int unsigned MAX_PATTERN_DEF = 16;
	localparam int unsigned OFFSET_BITS_DEF = 32;

	// Fixed field widths.
	localparam int unsigned PAT_BYTES = 16;
	localparam int unsigned PIDX_W    = 4;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned BACK_W    = 7;
	localparam int unsigned OFF_W     = 32;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CFG_W     = 64;

	// Result queue geometry.
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_AW    = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_MATCH_MASK     = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_REPORT_ALL     = 3'd4
	} reg_idx_t;

	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

	// Pattern settings broadcast to every cell of the window.
	typedef struct packed {
		logic [LEN_W-1:0]     len;
		pat_bytes_t           pattern;
		logic [PAT_BYTES-1:0] mask;
	} scan_cfg_t;

	// Per-cycle control of the window shift register.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// One result item.
	typedef struct packed {
		logic [OFF_W-1:0] match_offset;
		logic             is_match;
		logic             found_any;
		logic             done_res;
	} res_t;

	// Status of the result queue.
	typedef struct packed {
		logic valid;
		logic room2;
	} fifo_stat_t;

	// A byte that lies back positions before the current one faces pattern byte
	// len-1-back. It passes when it lies outside the pattern, the position is a
	// wildcard, or it equals the pattern byte.
	function automatic logic byte_ok(input logic [LEN_W-1:0] len,
	                                 input logic [BACK_W-1:0] back,
	                                 input scan_cfg_t cfg_in,
	                                 input logic [7:0] b);
		logic [BACK_W-1:0] diff;
		logic [PIDX_W-1:0] pidx;
		logic ok;
		diff = {{(BACK_W-LEN_W){1'b0}}, len} - back - BACK_W'(1);
		pidx = diff[PIDX_W-1:0];
		ok = 1'b1;
		if ({{(BACK_W-LEN_W){1'b0}}, len} > back) begin
			ok = !cfg_in.mask[pidx] || (cfg_in.pattern[pidx] == b);
		end
		return ok;
	endfunction

endpackage

// ===== rtl/mbps_in_if.sv =====
// Byte stream channel of the pattern scanner.
interface mbps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/mbps_out_if.sv =====
// Result channel of the pattern scanner.
interface mbps_out_if;
	import mbps_pkg::*;
	logic             valid;
	logic             ready;
	logic [OFF_W-1:0] match_offset;
	logic             is_match;
	logic             found_any;
	logic             done_res;

	modport source(output valid, output match_offset, output is_match, output found_any,
		output done_res, input ready);
	modport sink(input valid, input match_offset, input is_match, input found_any,
		input done_res, output ready);
endinterface

// ===== rtl/mbps_cfg_if.sv =====
// Register write channel of the pattern scanner.
interface mbps_cfg_if;
	import mbps_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     wdata;

	modport source(output valid, output reg_index, output wdata, input ready);
	modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/masked_byte_pattern_scanner_core.sv =====
// Top level of the masked byte pattern scanner: window cell chain, match logic, result queue.
//
//  Channel     Dir  Handshake     Payload
//  data_ch     in   valid/ready   data_byte[7:0], last_byte
//  result_ch   out  valid/ready   match_offset[31:0], is_match, found_any, done_res
//  cfg_ch      in   valid/ready   reg_index[2:0], wdata[63:0]
//
// Every byte item is compared in the cycle it is accepted, so the block takes one
// item per clock while data_ch.ready is high. The rate is set by the result queue: an
// item that produces both a match report and the done item puts two entries into it.
// Results are written into the result queue and handed out on result_ch from its head.
// data_ch.ready is high while the four-entry result queue has room for two items.
// Reset clears the window, the byte position, the seen flag and the queue, and loads
// the register reset values. cfg_ch is always ready.
module masked_byte_pattern_scanner_core #(
	parameter int unsigned MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
	parameter int unsigned OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mbps_in_if.sink     data_ch,
	mbps_out_if.source  result_ch,
	mbps_cfg_if.sink    cfg_ch
);
	import mbps_pkg::*;

	// The window holds the bytes before the current one.
	localparam int unsigned HIST_DEPTH = MAX_PATTERN - 1;
	// Longest pattern that can be used.
	localparam int unsigned CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

	// Configuration registers.
	logic [CFG_W-1:0]     pattern_low_q;
	logic [CFG_W-1:0]     pattern_high_q;
	logic [PAT_BYTES-1:0] match_mask_q;
	logic [LEN_W-1:0]     pattern_length_q;
	logic                 report_all_q;

	// Scan state.
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   seen_q;

	logic                 accept;
	logic [LEN_W-1:0]     len_eff;
	logic [LEN_W-1:0]     len_m1;
	scan_cfg_t            scan_cfg;
	cell_ctl_t            ctl;
	logic [7:0]           win [HIST_DEPTH+1];
	logic [HIST_DEPTH-1:0] cell_ok;
	logic                 head_ok;
	logic                 hit;
	logic                 report;
	logic [OFFSET_BITS-1:0] start;
	logic [OFF_W-1:0]     start_out;
	res_t                 match_item;
	res_t                 done_item;
	res_t                 d0;
	res_t                 d1;
	res_t                 head;
	logic [1:0]           push_n;
	logic                 pop;
	fifo_stat_t           stat;

	// Register writes. Writes beyond the list are dropped.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			match_mask_q     <= '1;
			pattern_length_q <= LEN_W'(1);
			report_all_q     <= 1'b1;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.reg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_ch.wdata;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_ch.wdata;
				REG_MATCH_MASK:     match_mask_q     <= cfg_ch.wdata[PAT_BYTES-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_ch.wdata[LEN_W-1:0];
				REG_REPORT_ALL:     report_all_q     <= cfg_ch.wdata[0];
				default: begin
				end
			endcase
		end
	end

	// A length above the longest supported pattern saturates.
	assign len_eff = (pattern_length_q > LEN_W'(CAP)) ? LEN_W'(CAP) : pattern_length_q;
	assign len_m1  = len_eff - LEN_W'(1);

	assign scan_cfg.len     = len_eff;
	assign scan_cfg.pattern = {pattern_high_q, pattern_low_q};
	assign scan_cfg.mask    = match_mask_q;

	assign data_ch.ready = stat.room2;
	assign accept        = data_ch.valid && data_ch.ready;

	// The window shifts on every byte but the last, which instead clears it
	// for the next buffer.
	assign ctl.shift = accept && !data_ch.last_byte;
	assign ctl.clear = accept && data_ch.last_byte;

	// Cell j holds the byte j+1 positions back; the newest byte enters cell 0.
	assign win[0] = data_ch.data_byte;

	for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_cell
		mbps_cell #(
			.BACK(j + 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.scan_cfg (scan_cfg),
			.din      (win[j]),
			.dout     (win[j+1]),
			.ok       (cell_ok[j])
		);
	end

	// The current byte faces the last pattern byte.
	assign head_ok = byte_ok(len_eff, BACK_W'(0), scan_cfg, data_ch.data_byte);

	// A match counts only if it starts inside the buffer.
	assign hit = (len_eff != '0) && (pos_q >= OFFSET_BITS'(len_m1)) && head_ok && (&cell_ok);
	assign report = hit && (report_all_q || !seen_q);

	assign start = pos_q - OFFSET_BITS'(len_m1);

	if (OFFSET_BITS >= OFF_W) begin : g_off_trunc
		assign start_out = start[OFF_W-1:0];
	end else begin : g_off_ext
		assign start_out = {{(OFF_W-OFFSET_BITS){1'b0}}, start};
	end

	assign match_item.match_offset = start_out;
	assign match_item.is_match     = 1'b1;
	assign match_item.found_any    = 1'b0;
	assign match_item.done_res     = 1'b0;

	assign done_item.match_offset = '0;
	assign done_item.is_match     = 1'b0;
	assign done_item.found_any    = seen_q || hit;
	assign done_item.done_res     = 1'b1;

	// A match report goes ahead of the done item of the same byte.
	always_comb begin
		push_n = 2'd0;
		d0     = done_item;
		d1     = done_item;
		if (accept) begin
			if (report) begin
				d0     = match_item;
				push_n = data_ch.last_byte ? 2'd2 : 2'd1;
			end else if (data_ch.last_byte) begin
				push_n = 2'd1;
			end
		end
	end

	// Byte position saturates at its all-ones value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (data_ch.last_byte) begin
				pos_q  <= '0;
				seen_q <= 1'b0;
			end else begin
				if (!(&pos_q)) begin
					pos_q <= pos_q + OFFSET_BITS'(1);
				end
				if (hit) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	mbps_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.d0     (d0),
		.d1     (d1),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	assign pop                    = stat.valid && result_ch.ready;
	assign result_ch.valid        = stat.valid;
	assign result_ch.match_offset = head.match_offset;
	assign result_ch.is_match     = head.is_match;
	assign result_ch.found_any    = head.found_any;
	assign result_ch.done_res     = head.done_res;

	a_pos_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && data_ch.last_byte) |=> ((pos_q == '0) && !seen_q))
		else $error("scan state not cleared after the last byte");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !data_ch.last_byte && !(&pos_q)) |=> (pos_q == $past(pos_q) + OFFSET_BITS'(1)))
		else $error("byte position did not advance");

	a_first_only: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && report && !report_all_q) |-> !seen_q)
		else $error("second match reported in find-first mode");

endmodule

// ===== rtl/mbps_cell.sv =====
// One window cell: holds a past byte, passes it on and checks it against its pattern byte.
module mbps_cell #(
	parameter int unsigned BACK = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbps_pkg::cell_ctl_t ctl,
	input  mbps_pkg::scan_cfg_t scan_cfg,
	input  logic [7:0]          din,
	output logic [7:0]          dout,
	output logic                ok
);
	import mbps_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else if (ctl.clear) begin
			byte_q <= 8'd0;
		end else if (ctl.shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	assign ok   = byte_ok(scan_cfg.len, BACK_W'(BACK), scan_cfg, byte_q);

endmodule

// ===== rtl/mbps_res_fifo.sv =====
// Small result queue that takes up to two items per cycle and hands out one.
module mbps_res_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  mbps_pkg::res_t       d0,
	input  mbps_pkg::res_t       d1,
	input  logic                 pop,
	output mbps_pkg::res_t       head,
	output mbps_pkg::fifo_stat_t stat
);
	import mbps_pkg::*;

	res_t              mem_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_q;
	logic [RES_AW-1:0] rd_q;
	logic [RES_AW:0]   count_q;
	logic [RES_AW-1:0] wr_next;

	assign wr_next = wr_q + RES_AW'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_next] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_AW'(push_n);
			rd_q    <= rd_q + RES_AW'(pop);
			count_q <= count_q + (RES_AW+1)'(push_n) - (RES_AW+1)'(pop);
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.valid = (count_q != '0);
	assign stat.room2 = (count_q <= (RES_AW+1)'(RES_DEPTH - 2));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (RES_AW+1)'(RES_DEPTH))
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> ((count_q + (RES_AW+1)'(push_n)) <= (RES_AW+1)'(RES_DEPTH)))
		else $error("push into a queue without room");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty result queue");

endmodule
